FILE: sv/tgadec_pkg.sv
// Shared types and constants of the truecolour TGA run-length decoder.
// Used by the parser, the output stage and the top level; no dependencies.
package tgadec_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_IDSKIP  = 3'd2,
    PH_PKTHDR  = 3'd3,
    PH_PIXDATA = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Header byte positions of interest.
  localparam logic [4:0] HdrIdLen    = 5'd0;
  localparam logic [4:0] HdrType     = 5'd2;
  localparam logic [4:0] HdrWidthLo  = 5'd12;
  localparam logic [4:0] HdrWidthHi  = 5'd13;
  localparam logic [4:0] HdrHeightLo = 5'd14;
  localparam logic [4:0] HdrHeightHi = 5'd15;
  localparam logic [4:0] HdrDepth    = 5'd16;
  localparam logic [4:0] HdrLast     = 5'd17;

  localparam logic [7:0] TypeRaw = 8'd2;
  localparam logic [7:0] TypeRle = 8'd10;

  localparam logic [2:0] DepthRgb  = 3'd3;
  localparam logic [2:0] DepthRgba = 3'd4;

  localparam logic [7:0] RunBias = 8'd127;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  pixel_bytes;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic        end_of_image;
  } result_t;

endpackage

FILE: sv/tgadec_in_stage.sv
// Input register of the decoder: holds one file byte and its start flag.
// Depends on nothing but the advance signal from the top level.
module tgadec_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] data_i,
  input  logic       sof_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] data_o,
  output logic       sof_o
);

  logic       vld_q;
  logic [7:0] data_q;
  logic       sof_q;

  // The held item leaves whenever the stage behind it advances.
  assign ready_o = !vld_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
      sof_q  <= sof_i;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;
  assign sof_o   = sof_q;

endmodule

FILE: sv/tgadec_parser.sv
// Header parser and pixel decoder: all parse state and the result logic.
// Depends on tgadec_pkg for the phase codes and the result structure.
module tgadec_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_i,
  input  logic                 sof_i,
  output logic                 res_valid_o,
  output tgadec_pkg::result_t  res_o
);

  tgadec_pkg::phase_e phase_q, phase_d;
  logic [4:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  id_left_q, id_left_d;
  logic        rle_q, rle_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [2:0]  depth_q, depth_d;
  logic [31:0] pix_left_q, pix_left_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic [7:0]  run_len_q, run_len_d;
  logic [1:0]  bip_q, bip_d;
  logic [23:0] color_q, color_d;
  logic        fbad_q, fbad_d;

  always_comb begin
    tgadec_pkg::phase_e ph;
    logic [4:0]  idx;
    logic [7:0]  rep;
    logic [31:0] remain;
    logic [7:0]  pkt_dec;
    logic [7:0]  id_dec;

    phase_d    = phase_q;
    hdr_idx_d  = hdr_idx_q;
    id_left_d  = id_left_q;
    rle_d      = rle_q;
    width_d    = width_q;
    height_d   = height_q;
    depth_d    = depth_q;
    pix_left_d = pix_left_q;
    pkt_left_d = pkt_left_q;
    run_len_d  = run_len_q;
    bip_d      = bip_q;
    color_d    = color_q;
    fbad_d     = fbad_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    // A start flag restarts the header whatever was in progress.
    ph  = sof_i ? tgadec_pkg::PH_HEADER : phase_q;
    idx = sof_i ? '0 : hdr_idx_q;
    if (sof_i) begin
      fbad_d = 1'b0;
    end

    rep     = (run_len_q != 8'd0) ? run_len_q : 8'd1;
    if ({24'd0, rep} > pix_left_q) begin
      rep = pix_left_q[7:0];
    end
    remain  = pix_left_q - {24'd0, rep};
    pkt_dec = pkt_left_q - 8'd1;
    id_dec  = id_left_q - 8'd1;

    unique case (ph)
      tgadec_pkg::PH_HEADER: begin
        unique case (idx)
          tgadec_pkg::HdrIdLen:    id_left_d = data_i;
          tgadec_pkg::HdrType: begin
            rle_d = (data_i == tgadec_pkg::TypeRle);
            if (data_i != tgadec_pkg::TypeRaw && data_i != tgadec_pkg::TypeRle) begin
              fbad_d = 1'b1;
            end
          end
          tgadec_pkg::HdrWidthLo:  width_d[7:0]   = data_i;
          tgadec_pkg::HdrWidthHi:  width_d[15:8]  = data_i;
          tgadec_pkg::HdrHeightLo: height_d[7:0]  = data_i;
          tgadec_pkg::HdrHeightHi: height_d[15:8] = data_i;
          tgadec_pkg::HdrDepth: begin
            if (data_i[7:3] == {2'd0, tgadec_pkg::DepthRgb} ||
                data_i[7:3] == {2'd0, tgadec_pkg::DepthRgba}) begin
              depth_d = data_i[5:3];
            end else begin
              fbad_d = 1'b1;
            end
          end
          default: ;
        endcase
        if (idx < tgadec_pkg::HdrLast) begin
          hdr_idx_d = idx + 5'd1;
        end else begin
          hdr_idx_d   = idx;
          res_valid_o = 1'b1;
          if (fbad_d) begin
            phase_d    = tgadec_pkg::PH_DONE;
            res_o.kind = tgadec_pkg::KIND_ERROR;
          end else begin
            pix_left_d = {16'd0, width_q} * {16'd0, height_q};
            bip_d      = '0;
            color_d    = '0;
            pkt_left_d = '0;
            run_len_d  = '0;
            res_o.kind         = tgadec_pkg::KIND_HEADER;
            res_o.image_width  = width_q;
            res_o.image_height = height_q;
            res_o.pixel_bytes  = depth_q;
            res_o.end_of_image = (width_q == 16'd0) || (height_q == 16'd0);
            if (res_o.end_of_image) begin
              phase_d = tgadec_pkg::PH_DONE;
            end else if (id_left_q != 8'd0) begin
              phase_d = tgadec_pkg::PH_IDSKIP;
            end else begin
              phase_d = rle_q ? tgadec_pkg::PH_PKTHDR : tgadec_pkg::PH_PIXDATA;
            end
          end
        end
      end
      tgadec_pkg::PH_IDSKIP: begin
        id_left_d = id_dec;
        if (id_dec == 8'd0) begin
          phase_d = rle_q ? tgadec_pkg::PH_PKTHDR : tgadec_pkg::PH_PIXDATA;
        end
      end
      tgadec_pkg::PH_PKTHDR: begin
        if (!data_i[7]) begin
          run_len_d  = '0;
          pkt_left_d = data_i + 8'd1;
        end else begin
          run_len_d  = data_i - tgadec_pkg::RunBias;
          pkt_left_d = 8'd1;
        end
        bip_d   = '0;
        color_d = '0;
        phase_d = tgadec_pkg::PH_PIXDATA;
      end
      tgadec_pkg::PH_PIXDATA: begin
        if ({1'b0, bip_q} + 3'd1 < depth_q) begin
          unique case (bip_q)
            2'd0:    color_d[7:0]   = color_q[7:0] | data_i;
            2'd1:    color_d[15:8]  = color_q[15:8] | data_i;
            2'd2:    color_d[23:16] = color_q[23:16] | data_i;
            default: ;
          endcase
          bip_d = bip_q + 2'd1;
        end else begin
          res_valid_o        = 1'b1;
          res_o.kind         = tgadec_pkg::KIND_RUN;
          res_o.pixel_bytes  = depth_q;
          res_o.green        = color_q[15:8];
          res_o.blue         = color_q[7:0];
          if (depth_q == tgadec_pkg::DepthRgba) begin
            res_o.red   = color_q[23:16];
            res_o.alpha = data_i;
          end else begin
            res_o.red   = data_i;
            res_o.alpha = '0;
          end
          res_o.repeat_count = rep;
          res_o.end_of_image = (remain == 32'd0);
          pix_left_d = remain;
          bip_d      = '0;
          color_d    = '0;
          if (remain == 32'd0) begin
            phase_d = tgadec_pkg::PH_DONE;
          end else if (rle_q) begin
            pkt_left_d = pkt_dec;
            if (pkt_dec == 8'd0) begin
              phase_d = tgadec_pkg::PH_PKTHDR;
            end
          end
        end
      end
      default: ;
    endcase

    // In the header phase the index must follow the restart even without a result.
    if (sof_i && ph == tgadec_pkg::PH_HEADER && idx < tgadec_pkg::HdrLast) begin
      phase_d = tgadec_pkg::PH_HEADER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tgadec_pkg::PH_IDLE;
      hdr_idx_q  <= '0;
      id_left_q  <= '0;
      rle_q      <= 1'b0;
      width_q    <= '0;
      height_q   <= '0;
      depth_q    <= tgadec_pkg::DepthRgb;
      pix_left_q <= '0;
      pkt_left_q <= '0;
      run_len_q  <= '0;
      bip_q      <= '0;
      color_q    <= '0;
      fbad_q     <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      hdr_idx_q  <= hdr_idx_d;
      id_left_q  <= id_left_d;
      rle_q      <= rle_d;
      width_q    <= width_d;
      height_q   <= height_d;
      depth_q    <= depth_d;
      pix_left_q <= pix_left_d;
      pkt_left_q <= pkt_left_d;
      run_len_q  <= run_len_d;
      bip_q      <= bip_d;
      color_q    <= color_d;
      fbad_q     <= fbad_d;
    end
  end

endmodule

FILE: sv/tgadec_out_stage.sv
// Result register of the decoder: holds one result item until it is taken.
// Depends on tgadec_pkg for the result structure.
module tgadec_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  tgadec_pkg::result_t res_i,
  input  logic                ready_i,
  output logic                valid_o,
  output tgadec_pkg::result_t res_o
);

  logic                vld_q;
  tgadec_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

FILE: sv/tga_rle_image_decoder_unit.sv
// Truecolour TGA stream decoder, one file byte per item, uncompressed and run-length.
// A byte that is accepted waits in the input register; its parse step loads any result item into the result register.
// Throughput: one byte per cycle, set by the single parse step between the input
// register and the result register; the whole pipeline stalls only while a result waits.
// Reset: asynchronous, active low; the parser waits for a start flag, both stages empty.
// Depends on tgadec_pkg, tgadec_in_stage, tgadec_parser and tgadec_out_stage.
module tga_rle_image_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
  input  logic        s_axis_tuser,  // start_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // image_width[15:0], image_height[31:16], pixel_bytes[34:32], red[42:35],
  // green[50:43], blue[58:51], alpha[66:59], repeat_count[74:67], zero[79:75]
  output logic [79:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast   // end_of_image
);

  logic                in_vld;
  logic [7:0]          in_data;
  logic                in_sof;
  logic                advance;
  logic                step;
  logic                res_vld;
  tgadec_pkg::result_t res;
  tgadec_pkg::result_t out_res;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign step    = in_vld && advance;

  tgadec_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .data_i    (s_axis_tdata),
    .sof_i     (s_axis_tuser),
    .advance_i (advance),
    .valid_o   (in_vld),
    .data_o    (in_data),
    .sof_o     (in_sof)
  );

  tgadec_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_i      (in_data),
    .sof_i       (in_sof),
    .res_valid_o (res_vld),
    .res_o       (res)
  );

  tgadec_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_vld),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res.repeat_count, out_res.alpha, out_res.blue,
                         out_res.green, out_res.red, out_res.pixel_bytes,
                         out_res.image_height, out_res.image_width};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.end_of_image;

endmodule
